// ===== sv/ufs2_block_map_walker_top_assert.svh =====
// Assertion macros for the block map walker.
// Used by the walker controller; expects clk_i and rst_ni in scope.
`ifndef UFS2_BLOCK_MAP_WALKER_TOP_ASSERT_SVH
`define UFS2_BLOCK_MAP_WALKER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define UFS2BMW_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define UFS2BMW_NEVER(name, expr, msg) \
  `UFS2BMW_ASSERT(name, !(expr), msg)
`else
`define UFS2BMW_ASSERT(name, prop, msg)
`define UFS2BMW_NEVER(name, expr, msg)
`endif
`endif

// ===== sv/ufs2bmw_pkg.sv =====
// Shared types, constants and helper functions of the block map walker.
// No dependencies; imported by every walker module.
`default_nettype none

package ufs2bmw_pkg;

  // Inode layout
  localparam int unsigned DIRECT_POINTERS = 12;
  localparam int unsigned INDIRECT_LEVELS = 3;
  localparam int unsigned DINODE_BYTES    = 256;
  localparam int unsigned DINODE_LOG2     = $clog2(DINODE_BYTES);
  localparam logic [63:0] SIZE_FIELD_OFS     = 64'h10;
  localparam logic [63:0] DIRECT_FIELD_OFS   = 64'h70;
  localparam logic [63:0] INDIRECT_FIELD_OFS = 64'hd0;
  localparam int unsigned WORD_BYTES = 8;
  localparam int unsigned WORD_LOG2  = $clog2(WORD_BYTES);

  // Geometry limits
  localparam logic [4:0] BSL_MIN = 5'd12;
  localparam logic [4:0] BSL_MAX = 5'd16;
  localparam logic [4:0] FSL_MIN = 5'd9;

  // Divider: two quotient bits per cycle over 32 bits
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  // Configuration port
  localparam int unsigned PADDR_W = 6;

  typedef enum logic [2:0] {
    REG_BSL   = 3'd0,
    REG_FSL   = 3'd1,
    REG_ISF   = 3'd2,
    REG_IPG   = 3'd3,
    REG_FPG   = 3'd4,
    REG_IMAGE = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [4:0]  block_size_log2;
    logic [4:0]  frag_size_log2;
    logic [31:0] inode_start_frag;
    logic [31:0] inodes_per_group;
    logic [31:0] frags_per_group;
    logic [47:0] image_bytes;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic [31:0]        inode_number;
    logic signed [63:0] file_offset;
    logic signed [63:0] request_length;
    logic [63:0]        reply_data;
    logic               reply_ok;
  } in_item_t;

  typedef struct packed {
    logic        out_kind;
    logic [63:0] read_address;
    logic [63:0] phys_address;
    logic        is_hole;
    logic [16:0] chunk_bytes;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic {
    KIND_REQUEST = 1'b0,
    KIND_REPLY   = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_EOF        = 2'd1,
    STAT_INODE_FAIL = 2'd2,
    STAT_BAD_ARGS   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE, PH_SIZE, PH_INODE_PTR, PH_INDIRECT
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_MUL, S_FRAG, S_BASE, S_CHK, S_MAP0, S_MAP1,
    S_LVL, S_DESC0, S_DESC1, S_FIN, S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    RA_SIZE, RA_DIRECT, RA_INDIRECT, RA_DESC
  } raddr_e;

  typedef enum logic [1:0] {
    EM_READ, EM_STATUS, EM_FINISH
  } emit_e;

  typedef struct packed {
    logic    take_req;
    logic    load_size;
    logic    load_ptr;
    logic    mul;
    logic    frag;
    logic    base;
    logic    map0;
    logic    map1;
    logic    lvl_take;
    logic    lvl_next;
    logic    desc0;
    logic    lvl_dec;
    logic    load_raddr;
    raddr_e  raddr_sel;
    logic    load_out;
    emit_e   emit_sel;
    status_e stat;
    logic    force_hole;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic args_bad;
    logic div_done;
    logic inode_oob;
    logic past_eof;
    logic len_zero;
    logic lbn_direct;
    logic lvl_fit;
    logic lvl_last;
    logic levels_zero;
    logic desc_fail;
  } dp_sts_t;

  // Clamp block size log2 into the supported range
  function automatic logic [4:0] eff_bsl(input logic [4:0] b);
    logic [4:0] r;
    r = b;
    if (r < BSL_MIN) r = BSL_MIN;
    if (r > BSL_MAX) r = BSL_MAX;
    return r;
  endfunction

  // Clamp fragment size log2 between its floor and the block size
  function automatic logic [4:0] eff_fsl(input logic [4:0] f, input logic [4:0] bsl);
    logic [4:0] r;
    r = f;
    if (r < FSL_MIN) r = FSL_MIN;
    if (r > bsl) r = bsl;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ufs2bmw_div.sv =====
// Iterative 32-bit unsigned divider, restoring, two quotient bits per cycle.
// Depends on ufs2bmw_pkg.
`default_nettype none

module ufs2bmw_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic [31:0] quotient_o,
  output logic [31:0] remainder_o,
  output logic        done_o
);
  import ufs2bmw_pkg::*;

  logic [31:0] q_q, r_q, d_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic busy_q, done_q;

  logic [32:0] r1, r1s, r2, r2s;
  logic        ge1, ge2;
  logic [31:0] q1, q2;

  // Two dependent restoring steps per cycle
  always_comb begin
    r1  = {r_q, q_q[31]};
    ge1 = r1 >= {1'b0, d_q};
    r1s = ge1 ? (r1 - {1'b0, d_q}) : r1;
    q1  = {q_q[30:0], ge1};
    r2  = {r1s[31:0], q1[31]};
    ge2 = r2 >= {1'b0, d_q};
    r2s = ge2 ? (r2 - {1'b0, d_q}) : r2;
    q2  = {q1[30:0], ge2};
  end

  // Load on start, then iterate until the last step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q    <= '0;
      r_q    <= '0;
      d_q    <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      q_q    <= dividend_i;
      r_q    <= '0;
      d_q    <= divisor_i;
      cnt_q  <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      q_q   <= q2;
      r_q   <= r2s[31:0];
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_LAST) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign quotient_o  = q_q;
  assign remainder_o = r_q;
  assign done_o      = done_q;

endmodule

`default_nettype wire

// ===== sv/ufs2bmw_dpath.sv =====
// Datapath of the block map walker: inode location, pointer arithmetic,
// bounds checks and the output register. Depends on ufs2bmw_pkg, ufs2bmw_div.
`default_nettype none

module ufs2bmw_dpath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ufs2bmw_pkg::cfg_t     cfg_i,
  input  ufs2bmw_pkg::in_item_t in_data_i,
  input  ufs2bmw_pkg::dp_cmd_t  cmd_i,
  output ufs2bmw_pkg::dp_sts_t  sts_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ufs2bmw_pkg::out_item_t out_data_o
);
  import ufs2bmw_pkg::*;

  logic [4:0]  bsl, fsl, sh;
  logic [63:0] image;
  logic [31:0] ipg_eff, quo, rem;
  logic        div_done;

  logic [63:0] offset_q, length_q, size_q, prod_q, frag_q, base_q;
  logic [63:0] lbn_q, diff_q, want_q, rbi_q, cur_q, raddr_q, desc_addr_q;
  logic        desc_bad_q;
  logic [1:0]  lvl_q, levels_q;
  out_item_t   out_q;
  logic        out_valid_q;

  logic [63:0] prod_c, span, ptr_base, ptr_hi, phys, raddr_c;
  logic [6:0]  span_sh, idx_sh;
  logic [12:0] idx_mask, idx;
  logic [64:0] desc_sum;
  logic [16:0] bsize, boff, room, chunk;
  logic        ptr_null, hole;
  out_item_t   out_c;

  // Effective geometry
  assign bsl     = eff_bsl(cfg_i.block_size_log2);
  assign fsl     = eff_fsl(cfg_i.frag_size_log2, bsl);
  assign sh      = bsl - 5'(WORD_LOG2);
  assign image   = 64'(cfg_i.image_bytes);
  assign ipg_eff = (cfg_i.inodes_per_group == '0) ? 32'd1 : cfg_i.inodes_per_group;

  ufs2bmw_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.take_req),
    .dividend_i  (in_data_i.inode_number),
    .divisor_i   (ipg_eff),
    .quotient_o  (quo),
    .remainder_o (rem),
    .done_o      (div_done)
  );

  // Group geometry product and pointer arithmetic
  always_comb begin
    prod_c   = 64'(cfg_i.frags_per_group) * 64'(quo);
    span_sh  = 7'(sh) * 7'(lvl_q);
    span     = 64'd1 << span_sh;
    idx_sh   = 7'(sh) * 7'(levels_q - 2'd1);
    idx_mask = 13'((14'd1 << sh) - 14'd1);
    idx      = 13'(rbi_q >> idx_sh) & idx_mask;
    ptr_hi   = cur_q >> (7'd64 - 7'(fsl));
    ptr_base = cur_q << fsl;
    desc_sum = {1'b0, ptr_base} + 65'({idx, 3'b000});
    ptr_null = (cur_q == '0) || cur_q[63];
    hole     = cmd_i.force_hole || ptr_null;
    bsize    = 17'd1 << bsl;
    boff     = offset_q[16:0] & (bsize - 17'd1);
    room     = bsize - boff;
    chunk    = (want_q < 64'(room)) ? want_q[16:0] : room;
    phys     = ptr_base + 64'(boff);
  end

  // Select the next read address
  always_comb begin
    case (cmd_i.raddr_sel)
      RA_SIZE:     raddr_c = base_q + SIZE_FIELD_OFS;
      RA_DIRECT:   raddr_c = base_q + DIRECT_FIELD_OFS + (lbn_q << WORD_LOG2);
      RA_INDIRECT: raddr_c = base_q + INDIRECT_FIELD_OFS +
                             (64'(lvl_q - 2'd1) << WORD_LOG2);
      RA_DESC:     raddr_c = desc_addr_q;
      default:     raddr_c = desc_addr_q;
    endcase
  end

  // Form the result item
  always_comb begin
    out_c = '0;
    case (cmd_i.emit_sel)
      EM_READ: begin
        out_c.out_kind     = KIND_REQUEST;
        out_c.read_address = raddr_q;
      end
      EM_STATUS: begin
        out_c.out_kind = KIND_REPLY;
        out_c.status   = cmd_i.stat;
      end
      EM_FINISH: begin
        out_c.out_kind     = KIND_REPLY;
        out_c.phys_address = hole ? 64'd0 : phys;
        out_c.is_hole      = hole;
        out_c.chunk_bytes  = chunk;
        out_c.status       = STAT_OK;
      end
      default: out_c = '0;
    endcase
  end

  // Status toward the controller
  always_comb begin
    sts_o.out_free    = !out_valid_q || !out_stall_i;
    sts_o.args_bad    = in_data_i.file_offset[63] || in_data_i.request_length[63];
    sts_o.div_done    = div_done;
    sts_o.inode_oob   = (image < 64'(DINODE_BYTES)) || (base_q > image - 64'(DINODE_BYTES));
    sts_o.past_eof    = offset_q >= size_q;
    sts_o.len_zero    = length_q == '0;
    sts_o.lbn_direct  = lbn_q < 64'(DIRECT_POINTERS);
    sts_o.lvl_fit     = lbn_q < span;
    sts_o.lvl_last    = lvl_q == 2'(INDIRECT_LEVELS);
    sts_o.levels_zero = levels_q == '0;
    sts_o.desc_fail   = desc_bad_q || (image < 64'(WORD_BYTES)) ||
                        (desc_addr_q > image - 64'(WORD_BYTES));
  end

  // Control state: level counters and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q    <= '0;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.take_req) levels_q <= '0;
      else if (cmd_i.lvl_take) levels_q <= lvl_q;
      else if (cmd_i.lvl_dec) levels_q <= levels_q - 2'd1;
      if (cmd_i.map1 && !sts_o.lbn_direct) lvl_q <= 2'd1;
      else if (cmd_i.lvl_next) lvl_q <= lvl_q + 2'd1;
      if (cmd_i.load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_req) begin
      offset_q <= 64'(in_data_i.file_offset);
      length_q <= 64'(in_data_i.request_length);
      cur_q    <= '0;
      rbi_q    <= '0;
    end
    if (cmd_i.load_size) size_q <= in_data_i.reply_data;
    if (cmd_i.load_ptr) cur_q <= in_data_i.reply_data;
    if (cmd_i.mul) prod_q <= prod_c;
    if (cmd_i.frag) frag_q <= prod_q + 64'(cfg_i.inode_start_frag);
    if (cmd_i.base) base_q <= (frag_q << fsl) + (64'(rem) << DINODE_LOG2);
    if (cmd_i.map0) begin
      lbn_q  <= offset_q >> bsl;
      diff_q <= size_q - offset_q;
    end
    if (cmd_i.map1) begin
      want_q <= (length_q < diff_q) ? length_q : diff_q;
      if (!sts_o.lbn_direct) lbn_q <= lbn_q - 64'(DIRECT_POINTERS);
    end
    if (cmd_i.lvl_take) rbi_q <= lbn_q;
    if (cmd_i.lvl_next) lbn_q <= lbn_q - span;
    if (cmd_i.desc0) begin
      desc_addr_q <= desc_sum[63:0];
      desc_bad_q  <= ptr_null || (ptr_hi != '0) || desc_sum[64];
    end
    if (cmd_i.load_raddr) raddr_q <= raddr_c;
    if (cmd_i.load_out) out_q <= out_c;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== sv/ufs2bmw_ctrl.sv =====
// Controller of the block map walker: walk sequencing and phase tracking.
// Depends on ufs2bmw_pkg and the assertion macro header.
`default_nettype none
`include "ufs2_block_map_walker_top_assert.svh"

module ufs2bmw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_kind_i,
  input  logic                 in_ok_i,
  output logic                 in_stall_o,
  input  ufs2bmw_pkg::dp_sts_t sts_i,
  output ufs2bmw_pkg::dp_cmd_t cmd_o
);
  import ufs2bmw_pkg::*;

  state_e  state_q, state_d;
  phase_e  phase_q, phase_d;
  emit_e   emit_sel_q, emit_sel_d;
  status_e stat_q, stat_d;
  logic    hole_q, hole_d;
  logic    accept;

  assign in_stall_o = state_q != S_IDLE;
  assign accept     = in_valid_i && !in_stall_o;

  // Hold state and pending emission
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      phase_q    <= PH_IDLE;
      emit_sel_q <= EM_STATUS;
      stat_q     <= STAT_OK;
      hole_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      emit_sel_q <= emit_sel_d;
      stat_q     <= stat_d;
      hole_q     <= hole_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    emit_sel_d = emit_sel_q;
    stat_d     = stat_q;
    hole_d     = hole_q;
    cmd_o      = '0;
    cmd_o.raddr_sel = RA_SIZE;
    cmd_o.emit_sel  = emit_sel_q;
    cmd_o.stat      = stat_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (in_kind_i == KIND_REQUEST)) begin
          cmd_o.take_req = 1'b1;
          phase_d = PH_IDLE;
          if (sts_i.args_bad) begin
            stat_d = STAT_BAD_ARGS;
            emit_sel_d = EM_STATUS;
            state_d = S_EMIT;
          end else begin
            state_d = S_DIV;
          end
        end else if (accept) begin
          case (phase_q)
            PH_SIZE: begin
              if (!in_ok_i) begin
                stat_d = STAT_INODE_FAIL;
                emit_sel_d = EM_STATUS;
                phase_d = PH_IDLE;
                state_d = S_EMIT;
              end else begin
                cmd_o.load_size = 1'b1;
                state_d = S_MAP0;
              end
            end
            PH_INODE_PTR, PH_INDIRECT: begin
              if (!in_ok_i && (phase_q == PH_INODE_PTR)) begin
                stat_d = STAT_INODE_FAIL;
                emit_sel_d = EM_STATUS;
                phase_d = PH_IDLE;
                state_d = S_EMIT;
              end else if (!in_ok_i) begin
                hole_d = 1'b1;
                phase_d = PH_IDLE;
                state_d = S_FIN;
              end else begin
                cmd_o.load_ptr = 1'b1;
                hole_d = 1'b0;
                if (sts_i.levels_zero) begin
                  phase_d = PH_IDLE;
                  state_d = S_FIN;
                end else begin
                  state_d = S_DESC0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_DIV: if (sts_i.div_done) state_d = S_MUL;
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_FRAG;
      end
      S_FRAG: begin
        cmd_o.frag = 1'b1;
        state_d = S_BASE;
      end
      S_BASE: begin
        cmd_o.base = 1'b1;
        state_d = S_CHK;
      end
      // Bounds-check the inode; report a failure if it lies outside the image, else read its size
      S_CHK: begin
        if (sts_i.inode_oob) begin
          stat_d = STAT_INODE_FAIL;
          emit_sel_d = EM_STATUS;
        end else begin
          cmd_o.load_raddr = 1'b1;
          cmd_o.raddr_sel = RA_SIZE;
          phase_d = PH_SIZE;
          emit_sel_d = EM_READ;
        end
        state_d = S_EMIT;
      end
      S_MAP0: begin
        cmd_o.map0 = 1'b1;
        if (sts_i.past_eof || sts_i.len_zero) begin
          stat_d = sts_i.past_eof ? STAT_EOF : STAT_OK;
          emit_sel_d = EM_STATUS;
          phase_d = PH_IDLE;
          state_d = S_EMIT;
        end else begin
          state_d = S_MAP1;
        end
      end
      S_MAP1: begin
        cmd_o.map1 = 1'b1;
        if (sts_i.lbn_direct) begin
          cmd_o.load_raddr = 1'b1;
          cmd_o.raddr_sel = RA_DIRECT;
          phase_d = PH_INODE_PTR;
          emit_sel_d = EM_READ;
          state_d = S_EMIT;
        end else begin
          state_d = S_LVL;
        end
      end
      // Find the indirect level that covers the block, or finish as a hole past the last level
      S_LVL: begin
        if (sts_i.lvl_fit) begin
          cmd_o.lvl_take = 1'b1;
          cmd_o.load_raddr = 1'b1;
          cmd_o.raddr_sel = RA_INDIRECT;
          phase_d = PH_INODE_PTR;
          emit_sel_d = EM_READ;
          state_d = S_EMIT;
        end else if (sts_i.lvl_last) begin
          hole_d = 1'b1;
          phase_d = PH_IDLE;
          state_d = S_FIN;
        end else begin
          cmd_o.lvl_next = 1'b1;
        end
      end
      S_DESC0: begin
        cmd_o.desc0 = 1'b1;
        state_d = S_DESC1;
      end
      S_DESC1: begin
        if (sts_i.desc_fail) begin
          hole_d = 1'b1;
          phase_d = PH_IDLE;
          state_d = S_FIN;
        end else begin
          cmd_o.load_raddr = 1'b1;
          cmd_o.raddr_sel = RA_DESC;
          cmd_o.lvl_dec = 1'b1;
          phase_d = PH_INDIRECT;
          emit_sel_d = EM_READ;
          state_d = S_EMIT;
        end
      end
      S_FIN: begin
        cmd_o.emit_sel = EM_FINISH;
        cmd_o.force_hole = hole_q;
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `UFS2BMW_ASSERT(a_load_when_free, cmd_o.load_out |-> sts_i.out_free, "result lost")
  `UFS2BMW_ASSERT(a_idle_reply_quiet, (accept && in_kind_i && (phase_q == PH_IDLE)) |=> (state_q == S_IDLE), "idle reply started work")
  `UFS2BMW_ASSERT(a_req_starts, (accept && !in_kind_i) |=> ((state_q == S_DIV) || (state_q == S_EMIT)), "request not started")
  `UFS2BMW_NEVER(a_fin_phase, (state_q == S_FIN) && (phase_q != PH_IDLE), "finish with walk open")

endmodule

`default_nettype wire

// ===== sv/ufs2_block_map_walker_top.sv =====
// Block map walker: once a request is accepted, the inode-per-group divider runs, then the
// multiply, add, shift and bounds-check steps lead to its first read request; each memory
// reply leads to its next read or result. Every accepted item yields at most one result,
// held in an output register so that the next item is taken while a result waits. Depends
// on ufs2bmw_pkg and submodules.
`default_nettype none

module ufs2_block_map_walker_top (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  ufs2bmw_pkg::in_item_t   in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output ufs2bmw_pkg::out_item_t  out_data_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ufs2bmw_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]             pwdata,
  output logic [63:0]             prdata,
  output logic                    pready
);
  import ufs2bmw_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_wr;
  dp_cmd_t  cmd;
  dp_sts_t  sts;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[PADDR_W-1:WORD_LOG2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_size_log2  <= 5'd15;
      cfg_q.frag_size_log2   <= 5'd12;
      cfg_q.inode_start_frag <= 32'd0;
      cfg_q.inodes_per_group <= 32'd1;
      cfg_q.frags_per_group  <= 32'd1;
      cfg_q.image_bytes      <= 48'd0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BSL:   cfg_q.block_size_log2  <= pwdata[4:0];
        REG_FSL:   cfg_q.frag_size_log2   <= pwdata[4:0];
        REG_ISF:   cfg_q.inode_start_frag <= pwdata[31:0];
        REG_IPG:   cfg_q.inodes_per_group <= pwdata[31:0];
        REG_FPG:   cfg_q.frags_per_group  <= pwdata[31:0];
        REG_IMAGE: cfg_q.image_bytes      <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (reg_idx)
      REG_BSL:   prdata = 64'(cfg_q.block_size_log2);
      REG_FSL:   prdata = 64'(cfg_q.frag_size_log2);
      REG_ISF:   prdata = 64'(cfg_q.inode_start_frag);
      REG_IPG:   prdata = 64'(cfg_q.inodes_per_group);
      REG_FPG:   prdata = 64'(cfg_q.frags_per_group);
      REG_IMAGE: prdata = 64'(cfg_q.image_bytes);
      default:   prdata = 64'd0;
    endcase
  end

  ufs2bmw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_data_i.kind),
    .in_ok_i    (in_data_i.reply_ok),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ufs2bmw_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
